// ===== design/kct_pkg.sv =====
// Package for the keyed counter table: request and status codes, field widths,
// and the command and status structs between controller and datapath.
// Depends on nothing; every design file but kct_ram imports it.
package kct_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned KEY_W      = 5 * WORD_W;
  localparam int unsigned IN_DATA_W  = 6 * WORD_W;
  localparam int unsigned IN_USER_W  = REQ_W;
  localparam int unsigned OUT_DATA_W = WORD_W;
  localparam int unsigned OUT_USER_W = 1 + ST_W;

  localparam logic [REQ_W-1:0] REQ_CREATE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_GET       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FETCH_ADD = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_EXISTS    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic scan_rd;
    logic decide;
    logic vread;
    logic vdata;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_val;
    logic out_free;
  } sts_t;

endpackage

// ===== design/keyed_counter_table_unit.sv =====
// Top level of the keyed counter table: associative table of 64-bit counters
// keyed by a 256-bit handle and a pointer id. Depends on kct_pkg, kct_ctrl,
// kct_dp and kct_ram.
//
// Requests enter on the s_axis channel: tuser carries the request type and
// tdata the four handle words, the pointer id and the operand. Each request
// produces exactly one result on the m_axis channel: tuser carries success
// and status, tdata the returned value.
// One request is handled at a time. The key scan reads one table entry per
// cycle from the key and valid stores; a get or fetch-and-add that hits then
// also reads the value store. The next request is taken once the result is
// loaded into the output register.
// After reset a clearing pass marks every entry free; s_axis_tready_o stays
// low during it.
// The result sits in an output register. The next request is taken while a
// result waits; a new result is held back until the receiver takes the
// previous one, and no request is accepted meanwhile.
module keyed_counter_table_unit #(
  parameter int unsigned TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0: handle_word0, handle_word1, handle_word2,
  // handle_word3, pointer_id, operand (64 bits each).
  input  logic [kct_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: req_type (3 bits).
  input  logic [kct_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Fields from bit 0: value_out (64 bits).
  output logic [kct_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Fields from bit 0: success (1 bit), status (2 bits).
  output logic [kct_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);
  import kct_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] addr;

  kct_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  kct_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

// ===== design/kct_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the valid, key and value stores; depends on nothing.
module kct_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/kct_ctrl.sv =====
// Controller of the keyed counter table: clearing pass, key scan sequencing,
// value access and result hand-off. Depends on kct_pkg.
module kct_ctrl #(
  parameter int unsigned TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kct_pkg::sts_t     sts_i,
  output kct_pkg::cmd_t     cmd_o,
  output logic [IDX_W-1:0]  addr_o
);
  import kct_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_FLUSH  = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_VREAD  = 8'b0010_0000,
    S_VDATA  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cnt_d          = '0;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_FLUSH;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_FLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.need_val ? S_VREAD : S_DONE;
      end
      S_VREAD: begin
        cmd_o.vread = 1'b1;
        state_d     = S_VDATA;
      end
      S_VDATA: begin
        cmd_o.vdata = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  assign addr_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/kct_dp.sv =====
// Datapath of the keyed counter table: request registers, the valid, key and
// value stores, scan compare, update logic and output register.
// Depends on kct_pkg and kct_ram.
module kct_dp #(
  parameter int unsigned TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kct_pkg::cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]               addr_i,
  output kct_pkg::sts_t                  sts_o,
  input  logic [kct_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [kct_pkg::IN_USER_W-1:0]  in_user_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kct_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [kct_pkg::OUT_USER_W-1:0] out_user_o
);
  import kct_pkg::*;

  logic [REQ_W-1:0]  req_q;
  logic [KEY_W-1:0]  key_q;
  logic [WORD_W-1:0] opnd_q;

  logic              cmp_en_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;

  logic              res_ok_q, res_ok_d;
  logic [ST_W-1:0]   res_st_q, res_st_d;
  logic [WORD_W-1:0] res_val_q, res_val_d;

  logic              out_valid_q;
  logic [WORD_W-1:0] out_val_q;
  logic              out_ok_q;
  logic [ST_W-1:0]   out_st_q;

  logic              vld_we, vld_wdata, vld_rdata;
  logic [IDX_W-1:0]  vld_waddr;
  logic              key_we;
  logic [KEY_W-1:0]  key_rdata;
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr;
  logic [WORD_W-1:0] val_wdata, val_rdata;

  kct_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_i),
    .rdata_o (vld_rdata)
  );

  kct_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_i),
    .rdata_o (key_rdata)
  );

  kct_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (cmd_i.vread),
    .raddr_i (hit_idx_q),
    .rdata_o (val_rdata)
  );

  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (cmd_i.load_req) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (cmp_en_q) begin
      if (!hit_q && vld_rdata && (key_rdata == key_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (!free_q && !vld_rdata) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  always_comb begin
    vld_we    = 1'b0;
    vld_waddr = addr_i;
    vld_wdata = 1'b0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    val_waddr = hit_idx_q;
    val_wdata = opnd_q;
    res_ok_d  = res_ok_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    if (cmd_i.clear_wr) begin
      vld_we = 1'b1;
    end
    if (cmd_i.decide) begin
      res_ok_d  = 1'b0;
      res_st_d  = ST_NOT_FOUND;
      res_val_d = opnd_q;
      case (req_q)
        REQ_CREATE: begin
          if (hit_q) begin
            res_st_d = ST_EXISTS;
          end else if (!free_q) begin
            res_st_d = ST_FULL;
          end else begin
            vld_we    = 1'b1;
            vld_waddr = free_idx_q;
            vld_wdata = 1'b1;
            key_we    = 1'b1;
            val_we    = 1'b1;
            val_waddr = free_idx_q;
            res_ok_d  = 1'b1;
            res_st_d  = ST_OK;
          end
        end
        REQ_REMOVE: begin
          if (hit_q) begin
            vld_we    = 1'b1;
            vld_waddr = hit_idx_q;
            res_ok_d  = 1'b1;
            res_st_d  = ST_OK;
          end
        end
        REQ_SET: begin
          if (hit_q) begin
            val_we   = 1'b1;
            res_ok_d = 1'b1;
            res_st_d = ST_OK;
          end
        end
        REQ_GET, REQ_FETCH_ADD: begin
          if (hit_q) begin
            res_ok_d = 1'b1;
            res_st_d = ST_OK;
          end
        end
        default: begin
          res_ok_d = 1'b0;
        end
      endcase
    end
    if (cmd_i.vdata) begin
      res_val_d = val_rdata;
      if (req_q == REQ_FETCH_ADD) begin
        val_we    = 1'b1;
        val_wdata = val_rdata + opnd_q;
      end
    end
  end

  assign sts_o.need_val = hit_q && ((req_q == REQ_GET) || (req_q == REQ_FETCH_ADD));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= in_user_i;
      key_q  <= in_data_i[KEY_W-1:0];
      opnd_q <= in_data_i[IN_DATA_W-1:KEY_W];
    end
    cmp_idx_q  <= addr_i;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    res_ok_q   <= res_ok_d;
    res_st_q   <= res_st_d;
    res_val_q  <= res_val_d;
    if (cmd_i.out_load) begin
      out_val_q <= res_val_q;
      out_ok_q  <= res_ok_q;
      out_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan_rd;
      hit_q    <= hit_d;
      free_q   <= free_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_val_q;
  assign out_user_o  = {out_st_q, out_ok_q};

endmodule

// ===== design/kct_checker.sv =====
// Port-level checker for the keyed counter table and its bind to the top
// level. Depends on kct_pkg and keyed_counter_table_unit.
module kct_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid_i,
  input logic                           s_tready_i,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [kct_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input logic [kct_pkg::OUT_USER_W-1:0] m_tuser_i
);
  import kct_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("Result withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("Stalled result changed.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("Request taken while another is in progress.");

  a_success_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tuser_i[0] == (m_tuser_i[2:1] == ST_OK)))
    else $error("Success flag disagrees with status.");

endmodule

bind keyed_counter_table_unit kct_checker u_kct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);
